@@ hdl/skl_pkg.sv @@
// Package for the soft-knee sample limiter: shared widths, defaults, the
// per-sample control word and the exp(-t) table entry builder.
// No dependencies.
`default_nettype none

package skl_pkg;

  // Fixed field widths of the sample stream
  localparam int SAMPLE_W = 24;
  localparam int OUT_W    = 22;

  // Default build parameters
  localparam int EXP_TABLE_ENTRIES_DEF = 256;
  localparam int FRAC_BITS_DEF         = 20;

  // Working precision of the table builder (Q.31)
  localparam int          W_BITS = 31;
  localparam logic [63:0] W_ONE  = 64'd1 << W_BITS;

  // Control word that rides along the pipeline with each sample
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;   // raw input, for the pass-through case
    logic                neg;      // input sign
    logic                invalid;  // non-finite source sample
    logic                above;    // magnitude past the knee
    logic                last;     // end-of-buffer marker
  } skl_item_t;

  // One table entry: exp(-32*y), y in Q.31 (y <= 0.5), rounded to Q.frac.
  // Taylor sum through the 20th-power term, then five squarings. Elaboration-time only.
  function automatic logic [63:0] exp_entry(input logic [63:0] y, input int frac);
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        s;
    int                 k;
    term = W_ONE;
    sum  = $signed(W_ONE);
    for (k = 1; k <= 20; k++) begin
      term = ((term * y) >> W_BITS) / 64'(k);
      if ((k & 1) != 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    s = (sum < 0) ? 64'd0 : 64'(sum);
    if (s > W_ONE) begin
      s = W_ONE;
    end
    for (k = 0; k < 5; k++) begin
      s = (s * s + (W_ONE >> 1)) >> W_BITS;
    end
    return (s + (64'd1 << (W_BITS - 1 - frac))) >> (W_BITS - frac);
  endfunction

endpackage

`default_nettype wire

@@ hdl/skl_stream_if.sv @@
// Valid/ready channel interfaces for the soft-knee sample limiter:
// the raw sample stream and the bounded result stream. Uses skl_pkg.
`default_nettype none

interface skl_sample_if;
  logic                          valid;
  logic                          ready;
  logic [skl_pkg::SAMPLE_W-1:0]  sample;
  logic                          sample_invalid;
  logic                          last_in_block;

  modport source (output valid, output sample, output sample_invalid,
                  output last_in_block, input ready);
  modport sink   (input valid, input sample, input sample_invalid,
                  input last_in_block, output ready);
endinterface

interface skl_result_if;
  logic                          valid;
  logic                          ready;
  logic [skl_pkg::OUT_W-1:0]     limited_sample;
  logic                          limiting_engaged;
  logic                          block_end;

  modport source (output valid, output limited_sample, output limiting_engaged,
                  output block_end, input ready);
  modport sink   (input valid, input limited_sample, input limiting_engaged,
                  input block_end, output ready);
endinterface

`default_nettype wire

@@ hdl/skl_front.sv @@
// First pipeline stage: magnitude, knee test, overdrive t = (|x|-knee)*10
// clamped to 16, and the table position p = t * EXP_TABLE_ENTRIES. Uses skl_pkg.
`default_nettype none

module skl_front #(
  parameter int EXP_TABLE_ENTRIES = skl_pkg::EXP_TABLE_ENTRIES_DEF,
  parameter int FRAC_BITS         = skl_pkg::FRAC_BITS_DEF,
  localparam int TW = FRAC_BITS + 5,
  localparam int NB = $clog2(EXP_TABLE_ENTRIES + 1),
  localparam int PW = TW + NB
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           up_valid,
  output      logic                           up_ready,
  input  wire logic [skl_pkg::SAMPLE_W-1:0]   sample,
  input  wire logic                           sample_invalid,
  input  wire logic                           last_in_block,
  output      logic                           dn_valid,
  input  wire logic                           dn_ready,
  output      skl_pkg::skl_item_t             item,
  output      logic [PW-1:0]                  pos
);

  localparam int          CW      = (FRAC_BITS + 1 > skl_pkg::SAMPLE_W) ?
                                    FRAC_BITS + 1 : skl_pkg::SAMPLE_W;
  localparam logic [63:0] ONE     = 64'd1 << FRAC_BITS;
  localparam logic [63:0] KNEE    = (64'd9 * ONE + 64'd5) / 64'd10;
  localparam logic [CW-1:0]   KNEE_C  = CW'(KNEE);
  localparam logic [CW+3:0]   T_MAX_W = (CW + 4)'(64'd16 * ONE);
  localparam logic [TW-1:0]   T_MAX   = TW'(64'd16 * ONE);

  logic                        neg;
  logic [skl_pkg::SAMPLE_W-1:0] mag;
  logic [CW-1:0]               mag_w;
  logic [CW-1:0]               excess;
  logic [CW+3:0]               t10;
  logic [TW-1:0]               t;
  logic [PW-1:0]               pos_next;
  skl_pkg::skl_item_t          item_next;

  // Magnitude; negative full scale maps to 2^23 with no wrap
  assign neg    = sample[skl_pkg::SAMPLE_W-1];
  assign mag    = neg ? (~sample + 1'b1) : sample;
  assign mag_w  = CW'(mag);
  assign excess = mag_w - KNEE_C;

  // t = excess * 10, clamped to 16.0
  assign t10 = ((CW + 4)'(excess) << 3) + ((CW + 4)'(excess) << 1);
  assign t   = (t10 > T_MAX_W) ? T_MAX : t10[TW-1:0];

  // Table position, Q.(FRAC_BITS+4) in units of one table step
  assign pos_next = PW'(t) * PW'(EXP_TABLE_ENTRIES);

  always_comb begin
    item_next.sample  = sample;
    item_next.neg     = neg;
    item_next.invalid = sample_invalid;
    item_next.above   = (mag_w > KNEE_C);
    item_next.last    = last_in_block;
  end

  // Stage handshake
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item <= item_next;
      pos  <= pos_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/skl_interp.sv @@
// Second pipeline stage: exp(-t) table lookup of two neighboring points and
// the slope-times-fraction product for linear interpolation. Uses skl_pkg.
`default_nettype none

module skl_interp #(
  parameter int EXP_TABLE_ENTRIES = skl_pkg::EXP_TABLE_ENTRIES_DEF,
  parameter int FRAC_BITS         = skl_pkg::FRAC_BITS_DEF,
  localparam int TW = FRAC_BITS + 5,
  localparam int NB = $clog2(EXP_TABLE_ENTRIES + 1),
  localparam int PW = TW + NB,
  localparam int EW = FRAC_BITS + 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 up_valid,
  output      logic                 up_ready,
  input  wire skl_pkg::skl_item_t   up_item,
  input  wire logic [PW-1:0]        pos,
  output      logic                 dn_valid,
  input  wire logic                 dn_ready,
  output      skl_pkg::skl_item_t   item,
  output      logic [EW-1:0]        base,
  output      logic [EW+15:0]       slope_prod
);

  localparam int           IW    = NB;
  localparam logic [IW-1:0] LAST = IW'(EXP_TABLE_ENTRIES);

  // exp(-16*i/N) at Q.FRAC_BITS, built at elaboration
  logic [EW-1:0] exp_tab [EXP_TABLE_ENTRIES + 1];

  for (genvar i = 0; i <= EXP_TABLE_ENTRIES; i++) begin : g_tab
    localparam logic [63:0] Y = ((64'(i) << 30) + 64'(EXP_TABLE_ENTRIES / 2)) /
                                64'(EXP_TABLE_ENTRIES);
    assign exp_tab[i] = EW'(skl_pkg::exp_entry(Y, FRAC_BITS));
  end

  logic [IW-1:0]   idx;
  logic [15:0]     frac;
  logic            at_end;
  logic [IW-1:0]   idx_a;
  logic [IW-1:0]   idx_b;
  logic [EW-1:0]   ea;
  logic [EW-1:0]   eb;
  logic [EW-1:0]   diff;
  logic [EW+15:0]  prod_next;

  // Segment index and 16-bit fraction from the position
  assign idx  = pos[TW-1 +: IW];
  assign frac = pos[TW-2 -: 16];

  // At t = 16 both points are the last entry, so the slope is zero
  assign at_end = (idx >= LAST);
  assign idx_a  = at_end ? LAST : idx;
  assign idx_b  = at_end ? LAST : idx + 1'b1;
  assign ea     = exp_tab[idx_a];
  assign eb     = exp_tab[idx_b];
  assign diff   = (ea >= eb) ? ea - eb : '0;

  assign prod_next = (EW + 16)'(diff) * (EW + 16)'(frac);

  // Stage handshake
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item       <= up_item;
      base       <= ea;
      slope_prod <= prod_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/skl_shape.sv @@
// Last two pipeline stages: finish the interpolation, scale (1 - e) by the
// knee span, then form the signed output and flags. Uses skl_pkg.
`default_nettype none

module skl_shape #(
  parameter int FRAC_BITS = skl_pkg::FRAC_BITS_DEF,
  localparam int EW = FRAC_BITS + 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        up_valid,
  output      logic                        up_ready,
  input  wire skl_pkg::skl_item_t          up_item,
  input  wire logic [EW-1:0]               base,
  input  wire logic [EW+15:0]              slope_prod,
  output      logic                        dn_valid,
  input  wire logic                        dn_ready,
  output      logic [skl_pkg::OUT_W-1:0]   limited_sample,
  output      logic                        limiting_engaged,
  output      logic                        block_end
);

  localparam int          SW     = FRAC_BITS;
  localparam int          PRW    = SW + EW;
  localparam logic [63:0] ONE    = 64'd1 << FRAC_BITS;
  localparam logic [63:0] KNEE   = (64'd9 * ONE + 64'd5) / 64'd10;
  localparam logic [EW-1:0]  ONE_C  = EW'(ONE);
  localparam logic [EW-1:0]  KNEE_C = EW'(KNEE);
  localparam logic [SW-1:0]  SPAN_C = SW'(ONE - KNEE);
  localparam logic [PRW:0]   HALF_C = (PRW + 1)'(ONE >> 1);

  // ---- stage 3: e = base - drop, then span * (1 - e)
  logic [EW+16:0]      drop_w;
  logic [EW:0]         drop;
  logic [EW-1:0]       e_raw;
  logic [EW-1:0]       e;
  logic [EW-1:0]       one_minus;
  logic [PRW-1:0]      span_prod_next;
  logic                mid_valid;
  logic                mid_ready;
  skl_pkg::skl_item_t  mid_item;
  logic [PRW-1:0]      span_prod;

  assign drop_w    = (EW + 17)'(slope_prod) + (EW + 17)'(17'h08000);
  assign drop      = drop_w[EW+16:16];
  assign e_raw     = ((EW + 1)'(base) < drop) ? '0 : EW'((EW + 1)'(base) - drop);
  assign e         = (e_raw > ONE_C) ? ONE_C : e_raw;
  assign one_minus = ONE_C - e;

  assign span_prod_next = PRW'(SPAN_C) * PRW'(one_minus);

  assign up_ready = !mid_valid || mid_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (up_ready) begin
      mid_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      mid_item  <= up_item;
      span_prod <= span_prod_next;
    end
  end

  // ---- stage 4: magnitude = knee + round(span_prod), apply sign
  logic [PRW:0]                 scaled_w;
  logic [EW-1:0]                lim;
  logic [skl_pkg::OUT_W-1:0]    lim_o;
  logic [skl_pkg::OUT_W-1:0]    y_next;
  logic                         eng_next;

  assign scaled_w = (PRW + 1)'(span_prod) + HALF_C;
  assign lim      = KNEE_C + EW'(scaled_w >> FRAC_BITS);
  assign lim_o    = skl_pkg::OUT_W'(lim);

  // Output select: invalid -> 0, at or below knee -> pass, else soft-limited
  always_comb begin
    if (mid_item.invalid) begin
      y_next   = '0;
      eng_next = 1'b1;
    end else if (!mid_item.above) begin
      y_next   = skl_pkg::OUT_W'(mid_item.sample);
      eng_next = 1'b0;
    end else begin
      y_next   = mid_item.neg ? (~lim_o + 1'b1) : lim_o;
      eng_next = 1'b1;
    end
  end

  assign mid_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (mid_ready) begin
      dn_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && mid_valid) begin
      limited_sample   <= y_next;
      limiting_engaged <= eng_next;
      block_end        <= mid_item.last;
    end
  end

endmodule

`default_nettype wire

@@ hdl/soft_knee_sample_limiter_top.sv @@
// Soft-knee sample limiter: four-stage valid/ready pipeline.
//
// Channels: raw (sink) carries one signed Q3.20 sample per transfer with an
// invalid flag and an end-of-buffer marker; bounded (source) returns one
// result per sample: the sample bounded to +/-1.0, an engaged flag and a
// copy of the end-of-buffer marker. Results come out in input order.
//
// A raw sample passes the stage 1, 2, 3 and 4 registers in order to bounded.
// Throughput: one sample per cycle while bounded.ready is high; each stage
// holds one sample, and the stages are split at the three multiplies
// (t * entries, slope * fraction, span * (1 - e)). The exp(-t) table is
// constant logic built at elaboration.
//
// Reset (rst, synchronous) empties all stages; no warm-up is needed.
// When bounded.ready is low the output stage holds its result; upstream
// stages keep filling bubbles, and raw.ready falls only once all four
// stages are full. Depends on skl_pkg, the stream interfaces and the stages.
`default_nettype none

module soft_knee_sample_limiter_top #(
  parameter int EXP_TABLE_ENTRIES = skl_pkg::EXP_TABLE_ENTRIES_DEF,
  parameter int FRAC_BITS         = skl_pkg::FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  skl_sample_if.sink   raw,
  skl_result_if.source bounded
);

  localparam int TW = FRAC_BITS + 5;
  localparam int NB = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int PW = TW + NB;
  localparam int EW = FRAC_BITS + 1;

  logic                 s1_valid;
  logic                 s1_ready;
  skl_pkg::skl_item_t   s1_item;
  logic [PW-1:0]        s1_pos;

  logic                 s2_valid;
  logic                 s2_ready;
  skl_pkg::skl_item_t   s2_item;
  logic [EW-1:0]        s2_base;
  logic [EW+15:0]       s2_prod;

  // Stage 1: knee test, overdrive and table position
  skl_front #(
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES),
    .FRAC_BITS         (FRAC_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .up_valid       (raw.valid),
    .up_ready       (raw.ready),
    .sample         (raw.sample),
    .sample_invalid (raw.sample_invalid),
    .last_in_block  (raw.last_in_block),
    .dn_valid       (s1_valid),
    .dn_ready       (s1_ready),
    .item           (s1_item),
    .pos            (s1_pos)
  );

  // Stage 2: table lookup and slope product
  skl_interp #(
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES),
    .FRAC_BITS         (FRAC_BITS)
  ) u_interp (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (s1_valid),
    .up_ready   (s1_ready),
    .up_item    (s1_item),
    .pos        (s1_pos),
    .dn_valid   (s2_valid),
    .dn_ready   (s2_ready),
    .item       (s2_item),
    .base       (s2_base),
    .slope_prod (s2_prod)
  );

  // Stages 3 and 4: knee shaping and output register
  skl_shape #(
    .FRAC_BITS (FRAC_BITS)
  ) u_shape (
    .clk              (clk),
    .rst              (rst),
    .up_valid         (s2_valid),
    .up_ready         (s2_ready),
    .up_item          (s2_item),
    .base             (s2_base),
    .slope_prod       (s2_prod),
    .dn_valid         (bounded.valid),
    .dn_ready         (bounded.ready),
    .limited_sample   (bounded.limited_sample),
    .limiting_engaged (bounded.limiting_engaged),
    .block_end        (bounded.block_end)
  );

endmodule

`default_nettype wire
